/* hw/rtl/pink_noise_filter_top_macros.svh */
// Assertion macros for the pink noise filter port-level checker.
`ifndef PINK_NOISE_FILTER_TOP_MACROS_SVH
`define PINK_NOISE_FILTER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PNF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pink noise filter check failed");

// Consequent must hold in the cycle after the antecedent.
`define PNF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pink noise filter check failed");

`endif

/* hw/rtl/pnf_pkg.sv */
// Types, constants, coefficient tables and microcode for the pink noise filter.
`timescale 1ns / 1ps

package pnf_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int STATE_W   = 24;
	localparam int IN_FRAC   = SAMPLE_W - 1;
	localparam int ST_FRAC   = STATE_W - 6;
	localparam int CF        = 20;
	localparam int NPOLES    = 6;
	localparam int COEF_W    = 21;
	localparam int MB_W      = 28;
	localparam int PROD_W    = COEF_W + MB_W;
	localparam int ACC_W     = PROD_W + 1;
	localparam int PINK_W    = STATE_W + 4;
	localparam int Q_W       = STATE_W + 2;
	localparam int CFG_IDX_W = 8;
	localparam int N_STEPS   = 21;
	localparam int STEP_W    = $clog2(N_STEPS);
	localparam int IDX_W     = $clog2(NPOLES);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [STATE_W-1:0]  state_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
	typedef logic [STEP_W-1:0]          step_t;
	typedef logic [IDX_W-1:0]           idx_t;

	localparam cfg_idx_t REG_OUT_MIN = cfg_idx_t'(0);
	localparam cfg_idx_t REG_OUT_MAX = cfg_idx_t'(1);

	localparam step_t STEP_IDLE = step_t'(0);
	localparam step_t STEP_OUT  = step_t'(N_STEPS - 1);

	localparam coef_t DIRECT_TAP = coef_t'(562246);
	localparam coef_t DELAY_TAP  = coef_t'(121557);
	localparam coef_t SIXTH      = coef_t'(174763);

	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_WAIT_IN,
		SEQ_WRITE_OUT
	} seq_t;

	typedef enum logic [2:0] {
		MA_POLE,
		MA_GAIN,
		MA_DIRECT,
		MA_DELAY,
		MA_SIXTH,
		MA_SPAN
	} mul_a_t;

	typedef enum logic [1:0] {
		MB_STATE,
		MB_WHITE,
		MB_T,
		MB_Q
	} mul_b_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	typedef enum logic [2:0] {
		WB_NONE,
		WB_INIT,
		WB_POLE,
		WB_DIRECT,
		WB_DELAY
	} wb_t;

	typedef struct packed {
		seq_t    seq;
		step_t   target;
		mul_a_t  ma;
		mul_b_t  mb;
		idx_t    idx;
		acc_op_t acc;
		wb_t     wb;
		idx_t    wb_idx;
	} ucode_t;

	function automatic coef_t pole_coef(input idx_t i);
		case (i)
			idx_t'(0): return coef_t'(1047381);
			idx_t'(1): return coef_t'(1041572);
			idx_t'(2): return coef_t'(1016070);
			idx_t'(3): return coef_t'(908591);
			idx_t'(4): return coef_t'(576717);
			idx_t'(5): return coef_t'(-798595);
			default:   return '0;
		endcase
	endfunction

	function automatic coef_t gain_coef(input idx_t i);
		case (i)
			idx_t'(0): return coef_t'(58215);
			idx_t'(1): return coef_t'(78723);
			idx_t'(2): return coef_t'(161326);
			idx_t'(3): return coef_t'(325568);
			idx_t'(4): return coef_t'(558841);
			idx_t'(5): return coef_t'(-17719);
			default:   return '0;
		endcase
	endfunction

	function automatic ucode_t uw(input seq_t s, input step_t t, input mul_a_t a,
		input mul_b_t b, input int i, input acc_op_t o, input wb_t w, input int wi);
		ucode_t u;
		u.seq    = s;
		u.target = t;
		u.ma     = a;
		u.mb     = b;
		u.idx    = idx_t'(i);
		u.acc    = o;
		u.wb     = w;
		u.wb_idx = idx_t'(wi);
		return u;
	endfunction

	// Pole i: multiply pole*state, then gain*white; both products pass through prod_q into acc,
	// and the sum is written back while the next pole's products run.
	function automatic ucode_t ucode(input step_t s);
		case (s)
			step_t'(0):  return uw(SEQ_WAIT_IN, STEP_IDLE, MA_POLE, MB_STATE, 0,
				ACC_HOLD, WB_INIT, 0);
			step_t'(1):  return uw(SEQ_NEXT, STEP_IDLE, MA_POLE, MB_STATE, 0, ACC_HOLD, WB_NONE, 0);
			step_t'(2):  return uw(SEQ_NEXT, STEP_IDLE, MA_GAIN, MB_WHITE, 0, ACC_LOAD, WB_NONE, 0);
			step_t'(3):  return uw(SEQ_NEXT, STEP_IDLE, MA_POLE, MB_STATE, 1, ACC_ADD, WB_NONE, 0);
			step_t'(4):  return uw(SEQ_NEXT, STEP_IDLE, MA_GAIN, MB_WHITE, 1, ACC_LOAD, WB_POLE, 0);
			step_t'(5):  return uw(SEQ_NEXT, STEP_IDLE, MA_POLE, MB_STATE, 2, ACC_ADD, WB_NONE, 0);
			step_t'(6):  return uw(SEQ_NEXT, STEP_IDLE, MA_GAIN, MB_WHITE, 2, ACC_LOAD, WB_POLE, 1);
			step_t'(7):  return uw(SEQ_NEXT, STEP_IDLE, MA_POLE, MB_STATE, 3, ACC_ADD, WB_NONE, 0);
			step_t'(8):  return uw(SEQ_NEXT, STEP_IDLE, MA_GAIN, MB_WHITE, 3, ACC_LOAD, WB_POLE, 2);
			step_t'(9):  return uw(SEQ_NEXT, STEP_IDLE, MA_POLE, MB_STATE, 4, ACC_ADD, WB_NONE, 0);
			step_t'(10): return uw(SEQ_NEXT, STEP_IDLE, MA_GAIN, MB_WHITE, 4, ACC_LOAD, WB_POLE, 3);
			step_t'(11): return uw(SEQ_NEXT, STEP_IDLE, MA_POLE, MB_STATE, 5, ACC_ADD, WB_NONE, 0);
			step_t'(12): return uw(SEQ_NEXT, STEP_IDLE, MA_GAIN, MB_WHITE, 5, ACC_LOAD, WB_POLE, 4);
			step_t'(13): return uw(SEQ_NEXT, STEP_IDLE, MA_DIRECT, MB_WHITE, 0, ACC_ADD, WB_NONE, 0);
			step_t'(14): return uw(SEQ_NEXT, STEP_IDLE, MA_DELAY, MB_WHITE, 0, ACC_LOAD, WB_POLE, 5);
			step_t'(15): return uw(SEQ_NEXT, STEP_IDLE, MA_DELAY, MB_WHITE, 0, ACC_LOAD, WB_DIRECT, 0);
			step_t'(16): return uw(SEQ_NEXT, STEP_IDLE, MA_SIXTH, MB_T, 0, ACC_HOLD, WB_DELAY, 0);
			step_t'(17): return uw(SEQ_NEXT, STEP_IDLE, MA_SIXTH, MB_T, 0, ACC_LOAD, WB_NONE, 0);
			step_t'(18): return uw(SEQ_NEXT, STEP_IDLE, MA_SPAN, MB_Q, 0, ACC_HOLD, WB_NONE, 0);
			step_t'(19): return uw(SEQ_NEXT, STEP_IDLE, MA_SPAN, MB_Q, 0, ACC_LOAD, WB_NONE, 0);
			step_t'(20): return uw(SEQ_WRITE_OUT, STEP_IDLE, MA_SPAN, MB_Q, 0,
				ACC_HOLD, WB_NONE, 0);
			default:     return uw(SEQ_NEXT, STEP_IDLE, MA_POLE, MB_STATE, 0,
				ACC_HOLD, WB_NONE, 0);
		endcase
	endfunction

endpackage

/* hw/rtl/pnf_white_if.sv */
// Input sample channel: valid/ready with one white noise sample.
`timescale 1ns / 1ps

interface pnf_white_if;
	import pnf_pkg::*;

	logic    valid;
	logic    ready;
	sample_t white_sample;

	modport source (output valid, output white_sample, input ready);
	modport sink (input valid, input white_sample, output ready);
endinterface

/* hw/rtl/pnf_pink_if.sv */
// Output sample channel: valid/ready with one pink noise sample.
`timescale 1ns / 1ps

interface pnf_pink_if;
	import pnf_pkg::*;

	logic    valid;
	logic    ready;
	sample_t pink_sample;

	modport source (output valid, output pink_sample, input ready);
	modport sink (input valid, input pink_sample, output ready);
endinterface

/* hw/rtl/pnf_cfg_if.sv */
// Configuration write channel: valid/ready with register index and data.
`timescale 1ns / 1ps

interface pnf_cfg_if;
	import pnf_pkg::*;

	logic     valid;
	logic     ready;
	cfg_idx_t index;
	sample_t  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/pink_noise_filter_top.sv */
// Top level of the pink noise filter: microcode sequencer, config registers, output register.
`timescale 1ns / 1ps

// Pink noise filter. Each white sample on the white channel becomes one pink sample on
// the pink channel, mapped into out_min..out_max and saturated. A 21-step microcode
// program runs all sixteen products (pole and gain terms of six accumulators, the direct
// and delayed taps, the 1/6 scale and the range mapping) through one shared 21x28
// multiplier, so the block takes a new sample only after the program has finished the
// last one. The result sits in an output register, so the next sample is taken while it
// waits; the program stalls only on its last step if that register is still full.
// Config writes are accepted at any time but must be made between samples.
module pink_noise_filter_top (
	input logic       clk,
	input logic       arst_n,
	pnf_white_if.sink white,
	pnf_pink_if.source pink,
	pnf_cfg_if.sink   cfg
);
	import pnf_pkg::*;

	step_t   step_q;
	sample_t out_min_q;
	sample_t out_max_q;
	logic    out_valid_q;
	sample_t out_data_q;

	ucode_t  uc;
	logic    in_xfer;
	logic    out_free;
	logic    out_write;
	sample_t pink_next;

	assign uc        = ucode(step_q);
	assign in_xfer   = white.valid & white.ready;
	assign out_free  = !out_valid_q || pink.ready;
	assign out_write = (uc.seq == SEQ_WRITE_OUT) && out_free;

	assign white.ready      = (uc.seq == SEQ_WAIT_IN);
	assign pink.valid       = out_valid_q;
	assign pink.pink_sample = out_data_q;
	assign cfg.ready        = 1'b1;

	pnf_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.uc           (uc),
		.white_load   (in_xfer),
		.white_sample (white.white_sample),
		.out_min      (out_min_q),
		.out_max      (out_max_q),
		.pink_next    (pink_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			case (uc.seq)
				SEQ_WAIT_IN: begin
					if (in_xfer)
						step_q <= step_t'(step_q + 1'b1);
					else
						step_q <= uc.target;
				end
				SEQ_WRITE_OUT: begin
					// hold on the last step until the output register frees up
					if (out_free)
						step_q <= uc.target;
				end
				default: step_q <= step_t'(step_q + 1'b1);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_write)
				out_valid_q <= 1'b1;
			else if (pink.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_write)
			out_data_q <= pink_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_min_q <= {1'b1, {(SAMPLE_W-1){1'b0}}};
			out_max_q <= {1'b0, {(SAMPLE_W-1){1'b1}}};
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_OUT_MIN: out_min_q <= cfg.data;
				REG_OUT_MAX: out_max_q <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

/* hw/rtl/pnf_datapath.sv */
// Shared-multiplier datapath of the pink noise filter, driven by microcode words.
`timescale 1ns / 1ps

module pnf_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  pnf_pkg::ucode_t  uc,
	input  logic             white_load,
	input  pnf_pkg::sample_t white_sample,
	input  pnf_pkg::sample_t out_min,
	input  pnf_pkg::sample_t out_max,
	output pnf_pkg::sample_t pink_next
);
	import pnf_pkg::*;

	localparam int WHITE_W = SAMPLE_W + ST_FRAC - IN_FRAC;
	localparam int R20_W   = ACC_W - CF;
	localparam int R18_W   = ACC_W - ST_FRAC;
	localparam int T_W     = STATE_W + 1;
	localparam int Y_W     = R20_W + 1;
	localparam int SPAN_W  = SAMPLE_W + 1;

	function automatic state_t sat_r20(input logic signed [R20_W-1:0] v);
		if ((&v[R20_W-1:STATE_W-1]) || !(|v[R20_W-1:STATE_W-1]))
			return v[STATE_W-1:0];
		return v[R20_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
	endfunction

	function automatic state_t sat_pink(input logic signed [PINK_W-1:0] v);
		if ((&v[PINK_W-1:STATE_W-1]) || !(|v[PINK_W-1:STATE_W-1]))
			return v[STATE_W-1:0];
		return v[PINK_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
	endfunction

	function automatic sample_t sat_out(input logic signed [Y_W-1:0] v);
		if ((&v[Y_W-1:SAMPLE_W-1]) || !(|v[Y_W-1:SAMPLE_W-1]))
			return v[SAMPLE_W-1:0];
		return v[Y_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
	endfunction

	state_t                    state_q [NPOLES];
	state_t                    delay_q;
	logic signed [WHITE_W-1:0] white_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [PINK_W-1:0]  pink_q;

	state_t                    state_rd;
	coef_t                     mul_a;
	logic signed [MB_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic signed [ACC_W-1:0]   acc_b20;
	logic signed [ACC_W-1:0]   acc_b18;
	logic signed [R20_W-1:0]   rnd20;
	logic signed [R18_W-1:0]   rnd18;
	logic signed [Q_W-1:0]     q_val;
	state_t                    sat20;
	logic signed [T_W-1:0]     t_val;
	logic signed [SPAN_W-1:0]  span;
	logic signed [Y_W-1:0]     y_wide;

	assign state_rd = (uc.idx < idx_t'(NPOLES)) ? state_q[uc.idx] : '0;

	// Round half up: add half an LSB, then shift arithmetically.
	assign acc_b20 = acc_q + (ACC_W'(1) <<< (CF - 1));
	assign acc_b18 = acc_q + (ACC_W'(1) <<< (ST_FRAC - 1));
	assign rnd20   = acc_b20[ACC_W-1:CF];
	assign rnd18   = acc_b18[ACC_W-1:ST_FRAC];
	assign q_val   = rnd18[Q_W-1:0];
	assign sat20   = sat_r20(rnd20);

	assign t_val = T_W'(sat_pink(pink_q)) + (T_W'(3) <<< ST_FRAC);
	assign span  = SPAN_W'(out_max) - SPAN_W'(out_min);

	assign y_wide    = Y_W'(rnd20) + Y_W'(out_min);
	assign pink_next = sat_out(y_wide);

	always_comb begin
		case (uc.ma)
			MA_POLE:   mul_a = pole_coef(uc.idx);
			MA_GAIN:   mul_a = gain_coef(uc.idx);
			MA_DIRECT: mul_a = DIRECT_TAP;
			MA_DELAY:  mul_a = DELAY_TAP;
			MA_SIXTH:  mul_a = SIXTH;
			MA_SPAN:   mul_a = COEF_W'(span);
			default:   mul_a = '0;
		endcase
	end

	always_comb begin
		case (uc.mb)
			MB_STATE: mul_b = MB_W'(state_rd);
			MB_WHITE: mul_b = MB_W'(white_q);
			MB_T:     mul_b = MB_W'(t_val);
			MB_Q:     mul_b = MB_W'(q_val);
			default:  mul_b = '0;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (white_load)
			white_q <= WHITE_W'(white_sample) <<< (ST_FRAC - IN_FRAC);
		case (uc.acc)
			ACC_LOAD: acc_q <= ACC_W'(prod_q);
			ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_q);
			default:  acc_q <= acc_q;
		endcase
		case (uc.wb)
			WB_INIT:   pink_q <= PINK_W'(delay_q);
			WB_POLE:   pink_q <= pink_q + PINK_W'(sat20);
			WB_DIRECT: pink_q <= pink_q + PINK_W'(rnd20);
			default:   pink_q <= pink_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NPOLES; i++)
				state_q[i] <= '0;
			delay_q <= '0;
		end else begin
			if (uc.wb == WB_POLE && uc.wb_idx < idx_t'(NPOLES))
				state_q[uc.wb_idx] <= sat20;
			if (uc.wb == WB_DELAY)
				delay_q <= sat20;
		end
	end

endmodule

/* hw/rtl/pnf_checker.sv */
// Port-level checker for the pink noise filter, bound to the top level.
`timescale 1ns / 1ps
`include "pink_noise_filter_top_macros.svh"

module pnf_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             white_valid,
	input logic             white_ready,
	input logic             pink_valid,
	input logic             pink_ready,
	input pnf_pkg::sample_t pink_sample
);
	import pnf_pkg::*;

	logic [1:0] pend_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = white_valid & white_ready;
	assign out_xfer = pink_valid & pink_ready;

	// samples taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({in_xfer, out_xfer})
				2'b10:   pend_q <= pend_q + 2'd1;
				2'b01:   pend_q <= pend_q - 2'd1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	`PNF_ASSERT_NEXT(a_out_hold, clk, arst_n, pink_valid && !pink_ready, pink_valid && $stable(pink_sample))
	`PNF_ASSERT_NEXT(a_no_back_to_back, clk, arst_n, in_xfer, !white_ready)
	`PNF_ASSERT_NOW(a_out_has_source, clk, arst_n, pink_valid, pend_q != 2'd0)
	`PNF_ASSERT_NOW(a_full_stall, clk, arst_n, pend_q == 2'd2, !white_ready)

endmodule

bind pink_noise_filter_top pnf_checker u_pnf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.white_valid (white.valid),
	.white_ready (white.ready),
	.pink_valid  (pink.valid),
	.pink_ready  (pink.ready),
	.pink_sample (pink.pink_sample)
);

/* sim/pink_noise_checker.sv */
// Checker for the pink noise filter: predicts every pink sample and compares it.
`timescale 1ns / 1ps

module pink_noise_checker
	import pnf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	pnf_white_if  white,
	pnf_pink_if   pink,
	pnf_cfg_if    cfg,
	output int    failures,
	output int    outstanding
);

	localparam longint POLE_K [NPOLES] = '{1047381, 1041572, 1016070, 908591, 576717, -798595};
	localparam longint GAIN_K [NPOLES] = '{58215, 78723, 161326, 325568, 558841, -17719};
	localparam longint TAP_DIRECT = 562246;
	localparam longint TAP_DELAY  = 121557;
	localparam longint ONE_SIXTH  = 174763;
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};
	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};

	state_t  poles [NPOLES];
	state_t  delayed;
	sample_t lo_bound;
	sample_t hi_bound;
	sample_t expected_pink [$];
	int      fail_count;

	function automatic longint round_shift(input longint v, input int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clamp(input longint v, input int w);
		longint hi_v;
		longint lo_v;
		hi_v = (longint'(1) <<< (w - 1)) - 1;
		lo_v = -hi_v - 1;
		if (v > hi_v)
			return hi_v;
		if (v < lo_v)
			return lo_v;
		return v;
	endfunction

	// Run one white sample through the filter state and map the sum into the range.
	function automatic sample_t advance_filter(input sample_t w);
		longint wide_white;
		longint sum;
		longint t;
		longint q;
		longint span;
		longint y;
		wide_white = longint'(w) <<< (ST_FRAC - IN_FRAC);
		sum = 0;
		for (int i = 0; i < NPOLES; i++) begin
			poles[i] = state_t'(clamp(round_shift(POLE_K[i] * longint'(poles[i]) +
				GAIN_K[i] * wide_white, CF), STATE_W));
			sum += longint'(poles[i]);
		end
		sum += longint'(delayed);
		sum += round_shift(TAP_DIRECT * wide_white, CF);
		sum = clamp(sum, STATE_W);
		delayed = state_t'(clamp(round_shift(TAP_DELAY * wide_white, CF), STATE_W));
		t = sum + (longint'(3) <<< ST_FRAC);
		q = round_shift(t * ONE_SIXTH, ST_FRAC);
		span = longint'(hi_bound) - longint'(lo_bound);
		y = longint'(lo_bound) + round_shift(q * span, CF);
		return sample_t'(clamp(y, SAMPLE_W));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NPOLES; i++)
				poles[i] = '0;
			delayed = '0;
			lo_bound = SAMPLE_MIN;
			hi_bound = SAMPLE_MAX;
			expected_pink.delete();
			fail_count = 0;
			failures <= 0;
			outstanding <= 0;
		end else begin
			sample_t want;
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_OUT_MIN: lo_bound = cfg.data;
					REG_OUT_MAX: hi_bound = cfg.data;
					default: ;
				endcase
			end
			// retire before queueing: a result never belongs to the sample taken at its own edge
			if (pink.valid && pink.ready) begin
				if (expected_pink.size() == 0) begin
					if (fail_count < 10)
						$display("pink sample %0d with no white sample pending", pink.pink_sample);
					fail_count++;
				end else begin
					want = expected_pink.pop_front();
					if (want !== pink.pink_sample) begin
						if (fail_count < 10)
							$display("pink sample mismatch: expected %0d, got %0d",
								want, pink.pink_sample);
						fail_count++;
					end
				end
			end
			if (white.valid && white.ready)
				expected_pink.insert(expected_pink.size(), advance_filter(white.white_sample));
			outstanding <= expected_pink.size();
			failures <= fail_count;
		end
	end

endmodule

/* sim/testbench.sv */
// Testbench top for the pink noise filter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
	import pnf_pkg::*;

	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};
	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
	localparam cfg_idx_t REG_SPARE_LO = cfg_idx_t'(2);
	localparam cfg_idx_t REG_SPARE_HI = '1;
	localparam int CHOKE_CYCLES = 400;
	localparam sample_t EDGE_SAMPLES [20] = '{
		16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh5555, 16'shAAAA,
		16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
		16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh0000
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic calm = 1'b0;
	int   choke_count = 0;
	int   failures;
	int   outstanding;

	pnf_white_if white_ch ();
	pnf_pink_if  pink_ch ();
	pnf_cfg_if   cfg_ch ();

	pink_noise_filter_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.white  (white_ch),
		.pink   (pink_ch),
		.cfg    (cfg_ch)
	);

	pink_noise_checker pink_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.white       (white_ch),
		.pink        (pink_ch),
		.cfg         (cfg_ch),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always #2 clk = ~clk;

	// Offer one white sample, with random idle cycles ahead of it unless calm; leave valid high.
	task automatic send_white(input sample_t v);
		while (!calm && $urandom_range(99) < 34) begin
			white_ch.valid <= 1'b0;
			white_ch.white_sample <= sample_t'($urandom);
			@(posedge clk);
		end
		white_ch.valid <= 1'b1;
		white_ch.white_sample <= v;
		do @(posedge clk); while (!white_ch.ready);
	endtask

	// Drop valid and wait until every predicted sample has come out.
	task automatic drain();
		white_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic load_range(input sample_t lo, input sample_t hi, input bit with_spare);
		cfg_idx_t idx [4];
		sample_t  val [4];
		idx = '{REG_SPARE_LO, REG_OUT_MAX, REG_OUT_MIN, REG_SPARE_HI};
		val = '{sample_t'($urandom), hi, lo, sample_t'($urandom)};
		for (int i = 0; i < 4; i++) begin
			if (with_spare || idx[i] == REG_OUT_MIN || idx[i] == REG_OUT_MAX) begin
				cfg_ch.valid <= 1'b1;
				cfg_ch.index <= idx[i];
				cfg_ch.data <= val[i];
				do @(posedge clk); while (!cfg_ch.ready);
			end
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// Pink side: random stalls, none while calm, and one long hold-off per request.
	initial begin
		int choke_served;
		choke_served = 0;
		pink_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (choke_count != choke_served) begin
				choke_served++;
				pink_ch.ready <= 1'b0;
				repeat (CHOKE_CYCLES) @(posedge clk);
			end
			pink_ch.ready <= calm || ($urandom_range(99) >= 34);
		end
	end

	initial begin
		sample_t level;
		white_ch.valid <= 1'b0;
		white_ch.white_sample <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// extremes and sign flips under the reset range
		foreach (EDGE_SAMPLES[i])
			send_white(EDGE_SAMPLES[i]);
		drain();

		load_range(sample_t'(-16384), sample_t'(16384), 1'b1);
		choke_count <= choke_count + 1;
		repeat (100) send_white(sample_t'($urandom));
		drain();

		// inverted range at the extremes, samples offered with no idle cycles between them
		load_range(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
		calm <= 1'b1;
		repeat (90) send_white(sample_t'($urandom));
		drain();
		calm <= 1'b0;

		level = sample_t'($urandom);
		load_range(level, level, 1'b1);
		repeat (40) send_white(sample_t'($urandom));
		drain();

		// hold near the top rail long enough to saturate the sum, then swing down
		load_range(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
		calm <= 1'b1;
		repeat (360) send_white(sample_t'(SAMPLE_MAX - $urandom_range(1023)));
		repeat (40) send_white(sample_t'(SAMPLE_MIN + $urandom_range(1023)));
		drain();
		calm <= 1'b0;

		repeat (2) begin
			load_range(sample_t'($urandom), sample_t'($urandom), 1'b1);
			repeat (40) send_white(sample_t'($urandom));
			drain();
		end

		repeat (30) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#3000000;
		$display("simulation failed");
		$finish;
	end

endmodule
